// ----- rtl/core/vdc_pkg.sv -----
// Package for the volume dispense controller core.
// Holds the phase type, setpoint limits, register indexes and the status
// struct shared by the sequencer, the setpoint unit and the top level.
package vdc_pkg;

   // fill cycle phases, codes match the phase_code result field
   typedef enum logic [2:0] {
      PH_NOCUP = 3'd0,
      PH_BEEP1 = 3'd1,
      PH_FILL  = 3'd2,
      PH_BEEP2 = 3'd3,
      PH_DONE  = 3'd4
   } phase_type;

   // setpoint range and step, in millilitres
   localparam logic [13:0] SET_MAX   = 14'd9990;
   localparam logic [13:0] SET_MIN   = 14'd10;
   localparam logic [13:0] SET_STEP  = 14'd10;
   localparam logic [13:0] SET_RESET = 14'd100;

   // register reset values
   localparam logic [15:0] BEEP_RESET   = 16'd1000;
   localparam logic [15:0] REPEAT_RESET = 16'd200;

   // register indexes
   localparam int unsigned CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BEEP_TICKS   = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_REPEAT_TICKS = 1'b1;

   // one pulse adds 2/9 ml: remainder of 2*pulses modulo 9
   localparam logic [3:0] VOL_PER_PULSE = 4'd2;
   localparam logic [3:0] VOL_DIVISOR   = 4'd9;

   // saturation limits
   localparam logic [15:0] COUNT_MAX = 16'hFFFF;

   // sequencer status toward the setpoint unit and the result register
   typedef struct packed {
      phase_type   phase_cur;
      phase_type   phase_nxt;
      logic [13:0] volume_nxt;
   } fsm_stat_type;

endpackage

// ----- rtl/core/volume_dispense_controller_core.sv -----
// Top level of the volume dispense controller core.
// Instantiates vdc_fsm and vdc_setpoint; uses vdc_pkg.
//
// Usage: one request per millisecond tick carries the cup sensor, the two
// setpoint buttons and a flow-meter edge flag. Each request gives exactly one
// response with the relay, buzzer and lamp drives, the setpoint, the volume
// of the latest fill and the phase code, all taken after that tick.
// A request is held in an input register; when it is processed, the state is
// updated and the response register loaded. rsp_valid comes from the response
// register, so a response follows its request through the input and response
// registers; throughput is one request per cycle while the response
// side keeps ready high. When the receiver stalls, the response holds, one
// more request may wait in the input register, and req_ready then drops.
// The csr port writes beep_ticks (index 0) and repeat_ticks (index 1) with
// no wait; write only while no request is in flight.
// Synchronous reset: phase no cup, setpoint 100 ml, volume 0, beep_ticks
// 1000, repeat_ticks 200, both channels empty.
module volume_dispense_controller_core (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_cup_present,
   input  logic                            req_up_pressed,
   input  logic                            req_down_pressed,
   input  logic                            req_flow_edge,
   // response channel
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_valve_on,
   output logic                            rsp_buzzer_on,
   output logic                            rsp_red_lamp,
   output logic                            rsp_green_lamp,
   output logic [13:0]                     rsp_target_volume,
   output logic [13:0]                     rsp_delivered_volume,
   output logic [2:0]                      rsp_phase_code,
   // register writes
   input  logic                            csr_wen,
   input  logic [vdc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [15:0]                     csr_wdata
);
   import vdc_pkg::*;

   logic         in_valid_ff;
   logic         in_cup_ff;
   logic         in_up_ff;
   logic         in_down_ff;
   logic         in_edge_ff;
   logic         out_valid_ff;
   logic         out_valve_ff;
   logic         out_buzzer_ff;
   logic         out_red_ff;
   logic         out_green_ff;
   logic [13:0]  out_target_ff;
   logic [13:0]  out_volume_ff;
   logic [2:0]   out_phase_ff;
   logic [15:0]  beep_ticks_ff;
   logic [15:0]  repeat_ticks_ff;
   logic         fire;
   logic         accept;
   fsm_stat_type fsm_stat;
   logic [13:0]  setpoint_cur;
   logic [13:0]  setpoint_nxt;
   phase_type    ph;

   // request is processed when the response register is free or draining
   assign fire      = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || fire;
   assign accept    = req_valid && req_ready;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         beep_ticks_ff   <= BEEP_RESET;
         repeat_ticks_ff <= REPEAT_RESET;
      end else if (csr_wen) begin
         unique case (csr_index)
            CSR_BEEP_TICKS:   beep_ticks_ff   <= csr_wdata;
            CSR_REPEAT_TICKS: repeat_ticks_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (accept) begin
         in_valid_ff <= 1'b1;
      end else if (fire) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_cup_ff  <= req_cup_present;
         in_up_ff   <= req_up_pressed;
         in_down_ff <= req_down_pressed;
         in_edge_ff <= req_flow_edge;
      end
   end

   // phase sequencer
   vdc_fsm u_fsm (
      .clock       (clock),
      .reset       (reset),
      .fire        (fire),
      .cup_present (in_cup_ff),
      .flow_edge   (in_edge_ff),
      .beep_ticks  (beep_ticks_ff),
      .setpoint    (setpoint_cur),
      .fsm_stat    (fsm_stat)
   );

   // setpoint and button repeat
   vdc_setpoint u_setpoint (
      .clock        (clock),
      .reset        (reset),
      .fire         (fire),
      .up_pressed   (in_up_ff),
      .down_pressed (in_down_ff),
      .repeat_ticks (repeat_ticks_ff),
      .fsm_stat     (fsm_stat),
      .setpoint_cur (setpoint_cur),
      .setpoint_nxt (setpoint_nxt)
   );

   // response register
   assign ph = fsm_stat.phase_nxt;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (fire) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_valve_ff  <= (ph == PH_FILL);
         out_buzzer_ff <= (ph == PH_BEEP1) || (ph == PH_BEEP2);
         out_red_ff    <= (ph == PH_BEEP1) || (ph == PH_FILL) || (ph == PH_BEEP2);
         out_green_ff  <= (ph == PH_NOCUP) || (ph == PH_DONE);
         out_target_ff <= setpoint_nxt;
         out_volume_ff <= fsm_stat.volume_nxt;
         out_phase_ff  <= ph;
      end
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_valve_on         = out_valve_ff;
   assign rsp_buzzer_on        = out_buzzer_ff;
   assign rsp_red_lamp         = out_red_ff;
   assign rsp_green_lamp       = out_green_ff;
   assign rsp_target_volume    = out_target_ff;
   assign rsp_delivered_volume = out_volume_ff;
   assign rsp_phase_code       = out_phase_ff;

   // every processed request shows up as a response next cycle
   a_fire_rsp: assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_valid)
      else $error("processed request produced no response");

endmodule

// ----- rtl/core/vdc_setpoint.sv -----
// Setpoint unit: button auto-repeat timer and the setpoint register.
// Depends on vdc_pkg for limits and the sequencer status struct.
module vdc_setpoint (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  logic                 up_pressed,
   input  logic                 down_pressed,
   input  logic [15:0]          repeat_ticks,
   input  vdc_pkg::fsm_stat_type fsm_stat,
   output logic [13:0]          setpoint_cur,
   output logic [13:0]          setpoint_nxt
);
   import vdc_pkg::*;

   logic [13:0] setpoint_ff;
   logic [13:0] setpoint_in;
   logic [15:0] repeat_timer_ff;
   logic [15:0] repeat_timer_in;
   logic        idle;
   logic        up_ok;
   logic        down_ok;
   logic        act;
   logic [15:0] timer_inc;
   logic [13:0] sp_up;

   // buttons only act while no cup or done
   assign idle    = (fsm_stat.phase_cur == PH_NOCUP) || (fsm_stat.phase_cur == PH_DONE);
   assign up_ok   = up_pressed && (setpoint_ff < SET_MAX);
   assign down_ok = down_pressed && (setpoint_ff > SET_MIN);
   assign act     = idle && (up_ok || down_ok);

   // saturating repeat count
   assign timer_inc = (repeat_timer_ff != COUNT_MAX) ? repeat_timer_ff + 16'd1
                                                     : repeat_timer_ff;

   // up step first, then down step on the stepped value
   always_comb begin
      sp_up           = up_ok ? setpoint_ff + SET_STEP : setpoint_ff;
      setpoint_in     = setpoint_ff;
      repeat_timer_in = 16'd0;
      if (act) begin
         if (timer_inc >= repeat_ticks) begin
            setpoint_in = (down_pressed && (sp_up > SET_MIN)) ? sp_up - SET_STEP : sp_up;
         end else begin
            repeat_timer_in = timer_inc;
         end
      end
   end

   // state registers, advanced once per request
   always_ff @(posedge clock) begin
      if (reset) begin
         setpoint_ff     <= SET_RESET;
         repeat_timer_ff <= 16'd0;
      end else if (fire) begin
         setpoint_ff     <= setpoint_in;
         repeat_timer_ff <= repeat_timer_in;
      end
   end

   assign setpoint_cur = setpoint_ff;
   assign setpoint_nxt = setpoint_in;

   // setpoint never leaves its range
   a_sp_range: assert property (@(posedge clock) disable iff (reset)
      (setpoint_ff >= SET_MIN) && (setpoint_ff <= SET_MAX))
      else $error("setpoint out of range");

   // repeat timer is cleared after any request outside idle phases
   a_rt_clear: assert property (@(posedge clock) disable iff (reset)
      fire && !idle |=> (repeat_timer_ff == 16'd0))
      else $error("repeat timer not cleared during fill cycle");

endmodule

// ----- rtl/core/vdc_fsm.sv -----
// Fill sequencer: phase state machine, beep timer, pulse count and volume.
// Depends on vdc_pkg for the phase type and the status struct.
module vdc_fsm (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  logic                  cup_present,
   input  logic                  flow_edge,
   input  logic [15:0]           beep_ticks,
   input  logic [13:0]           setpoint,
   output vdc_pkg::fsm_stat_type fsm_stat
);
   import vdc_pkg::*;

   phase_type   phase_ff;
   phase_type   phase_in;
   logic [15:0] beep_timer_ff;
   logic [15:0] beep_timer_in;
   logic [15:0] pulse_ff;
   logic [15:0] pulse_in;
   logic [13:0] volume_ff;
   logic [13:0] volume_in;
   logic [3:0]  rem_ff;
   logic [3:0]  rem_in;
   logic        beep_over;
   logic        count;
   logic [3:0]  rem_sum;
   logic        carry;
   logic [13:0] volume_calc;

   assign beep_over = beep_timer_ff >= beep_ticks;

   // volume tracked incrementally as floor(2*pulses/9)
   assign count       = flow_edge && (pulse_ff != COUNT_MAX);
   assign rem_sum     = rem_ff + (count ? VOL_PER_PULSE : 4'd0);
   assign carry       = rem_sum >= VOL_DIVISOR;
   assign volume_calc = volume_ff + {13'd0, carry};

   // next phase and datapath
   always_comb begin
      phase_in      = phase_ff;
      beep_timer_in = beep_timer_ff;
      pulse_in      = pulse_ff;
      volume_in     = volume_ff;
      rem_in        = rem_ff;
      unique case (phase_ff)
         PH_BEEP1: begin
            if (beep_over) begin
               phase_in  = PH_FILL;
               pulse_in  = 16'd0;
               volume_in = 14'd0;
               rem_in    = 4'd0;
            end else begin
               beep_timer_in = beep_timer_ff + 16'd1;
            end
         end
         PH_FILL: begin
            if (!cup_present) begin
               phase_in      = PH_BEEP2;
               beep_timer_in = 16'd1;
            end else begin
               pulse_in  = pulse_ff + {15'd0, count};
               volume_in = volume_calc;
               rem_in    = carry ? rem_sum - VOL_DIVISOR : rem_sum;
               if (volume_calc >= setpoint) begin
                  phase_in      = PH_BEEP2;
                  beep_timer_in = 16'd1;
               end
            end
         end
         PH_BEEP2: begin
            if (beep_over) begin
               phase_in = PH_DONE;
            end else begin
               beep_timer_in = beep_timer_ff + 16'd1;
            end
         end
         PH_DONE: begin
            if (!cup_present) begin
               phase_in = PH_NOCUP;
            end
         end
         default: begin
            // no cup, and any stray code behaves the same
            if (cup_present) begin
               phase_in      = PH_BEEP1;
               beep_timer_in = 16'd1;
            end else begin
               phase_in = PH_NOCUP;
            end
         end
      endcase
   end

   // state registers, advanced once per request
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_NOCUP;
         beep_timer_ff <= 16'd0;
         pulse_ff      <= 16'd0;
         volume_ff     <= 14'd0;
         rem_ff        <= 4'd0;
      end else if (fire) begin
         phase_ff      <= phase_in;
         beep_timer_ff <= beep_timer_in;
         pulse_ff      <= pulse_in;
         volume_ff     <= volume_in;
         rem_ff        <= rem_in;
      end
   end

   assign fsm_stat.phase_cur  = phase_ff;
   assign fsm_stat.phase_nxt  = phase_in;
   assign fsm_stat.volume_nxt = volume_in;

   // while filling the setpoint has not yet been reached
   a_fill_below: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_FILL) |-> (volume_ff < setpoint))
      else $error("filling past setpoint");

   // volume remainder stays a proper residue
   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      rem_ff < VOL_DIVISOR)
      else $error("volume remainder out of range");

endmodule
